[rtl/core/bascc_pkg.sv]
// Shared constants, widths and controller/datapath types for the block-average steering core.
package bascc_pkg;

   // Samples per averaging block.
   localparam int BLOCK_LENGTH = 64;

   // Field widths.
   localparam int SAMPLE_W = 10;
   localparam int MEAN_W   = 10;
   localparam int TARGET_W = 10;
   localparam int OFFSET_W = 14;
   localparam int SPAN_W   = 12;
   localparam int BASE_W   = 8;
   localparam int POWER_W  = 15;
   localparam int ERR_W    = 15;
   localparam int Q_FRAC   = 14;

   // Accumulator widths follow from the block length.
   localparam int CNT_W = (BLOCK_LENGTH > 2) ? $clog2(BLOCK_LENGTH) : 1;
   localparam int SUM_W = $clog2(BLOCK_LENGTH * 1023 + 1);

   // Power product widths: base times mean, then times the error factor.
   localparam int FACTOR_W = 15;
   localparam int BM_W     = BASE_W + MEAN_W;
   localparam int PROD_W   = BM_W + FACTOR_W;

   // Shared serial divider: 24-bit dividend, 12-bit divisor, one bit per cycle.
   localparam int DIV_W     = 24;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // Stream payload widths.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE   = 2'd3;

   // Register reset values.
   localparam logic [TARGET_W-1:0] TARGET_RESET = 10'd350;
   localparam logic [OFFSET_W-1:0] OFFSET_RESET = 14'd3604;
   localparam logic [SPAN_W-1:0]   SPAN_RESET   = 12'd600;
   localparam logic [BASE_W-1:0]   BASE_RESET   = 8'd127;

   localparam logic [POWER_W-1:0] POWER_MAX = 15'h7FFF;
   localparam logic [ERR_W:0]     Q_ONE     = 16'h4000;

   // Controller states, one-hot.
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_QDIV  = 8'b0000_0010,
      ST_QWAIT = 8'b0000_0100,
      ST_MUL1  = 8'b0000_1000,
      ST_MUL2  = 8'b0001_0000,
      ST_PDIV  = 8'b0010_0000,
      ST_PWAIT = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // take the input transaction into the accumulators
      logic div_start;  // launch the serial divider
      logic div_power;  // divider operands: 1 = power quotient, 0 = error quotient
      logic q_capture;  // store the clamped steering error
      logic mul1;       // base power times numerator mean
      logic mul2;       // times the error factor
      logic p_capture;  // store a saturated power
      logic side;       // 0 = right motor, 1 = left motor
      logic rsp_load;   // load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic div_done;
   } status_type;

endpackage

[rtl/core/block_average_steering_control_core.sv]
// Top level of the block-average steering control core.
//
// Each req transaction carries one rear and one front distance sample. The
// core adds both into block sums and, on the last sample of a block, latches
// the block means. For every req transaction it returns one rsp transaction
// with the clamped steering error and the left and right motor powers.
// Registers are written through the csr channel, which is always ready; write
// only while the core is idle.
// The next request is taken in the same cycle that the result is presented,
// so the core takes a new request only once the previous one is finished. Its
// pace is set by the shared one-bit-per-cycle divider, which runs three
// 24-step divisions per item (error quotient, right power, left power).
// A finished result waits in the output register; the core accepts and works
// on the next request meanwhile and stalls only before loading a new result.
// Reset restores the register defaults and clears the sums, count and means.
module block_average_steering_control_core (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [9:0] rear_sample, [19:10] front_sample, [23:20] zero
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bascc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: [14:0] left_power, [29:15] right_power, [44:30] steer_error,
   // [47:45] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bascc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // rsp_tuser: [0] zero_average, [1] power_clipped
   output logic [bascc_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bascc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bascc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import bascc_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic [POWER_W-1:0] left_power, right_power;
   logic [ERR_W-1:0]   steer_error;
   logic               zero_average, power_clipped;

   assign csr_ready = 1'b1;

   bascc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bascc_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rear_sample   (req_tdata[SAMPLE_W-1:0]),
      .front_sample  (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .cmd           (cmd),
      .status        (status),
      .left_power    (left_power),
      .right_power   (right_power),
      .steer_error   (steer_error),
      .zero_average  (zero_average),
      .power_clipped (power_clipped)
   );

   // Pack the result fields, lowest field first.
   assign rsp_tdata = {{(RSP_DATA_W - 2*POWER_W - ERR_W){1'b0}},
                       steer_error, right_power, left_power};
   assign rsp_tuser = {power_clipped, zero_average};

endmodule

[rtl/core/bascc_div.sv]
// Restoring unsigned divider that retires one quotient bit per cycle.
module bascc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [bascc_pkg::DIV_W-1:0]   dividend,
   input  logic [bascc_pkg::SPAN_W-1:0]  divisor,
   output logic                          done,
   output logic [bascc_pkg::DIV_W-1:0]   quotient
);
   import bascc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]     work_ff, work_in;
   logic [SPAN_W-1:0]    divisor_ff, divisor_in;
   logic [SPAN_W-1:0]    rem_ff, rem_in;
   logic [SPAN_W:0]      trial;
   logic                 fits;

   // One trial subtraction of the shifted remainder.
   assign trial = {rem_ff, work_ff[DIV_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         work_in    = dividend;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (busy_ff) begin
         // The dividend register fills with quotient bits from the bottom.
         rem_in  = fits ? SPAN_W'(trial - {1'b0, divisor_ff}) : trial[SPAN_W-1:0];
         work_in = {work_ff[DIV_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

[rtl/core/bascc_dp.sv]
// Datapath: configuration registers, block accumulators, error and power arithmetic.
module bascc_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [bascc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bascc_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [bascc_pkg::SAMPLE_W-1:0]    rear_sample,
   input  logic [bascc_pkg::SAMPLE_W-1:0]    front_sample,
   input  bascc_pkg::cmd_type                cmd,
   output bascc_pkg::status_type             status,
   output logic [bascc_pkg::POWER_W-1:0]     left_power,
   output logic [bascc_pkg::POWER_W-1:0]     right_power,
   output logic [bascc_pkg::ERR_W-1:0]       steer_error,
   output logic                              zero_average,
   output logic                              power_clipped
);
   import bascc_pkg::*;

   // Configuration registers.
   logic [TARGET_W-1:0] target_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [BASE_W-1:0]   base_ff;

   // Accumulator state.
   logic [CNT_W-1:0]  count_ff;
   logic [SUM_W-1:0]  rear_sum_ff, front_sum_ff;
   logic [SUM_W-1:0]  rear_sum_in, front_sum_in;
   logic [MEAN_W-1:0] rear_mean_ff, front_mean_ff;
   logic              block_end;

   // Arithmetic registers.
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [BM_W-1:0]    bm_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [POWER_W-1:0] right_ff, left_ff, power_in;
   logic               clip_r_ff, clip_l_ff, clip_in;

   // Result register.
   logic [POWER_W-1:0] rsp_left_ff, rsp_right_ff;
   logic [ERR_W-1:0]   rsp_err_ff;
   logic               rsp_zero_ff, rsp_clip_ff;

   logic signed [MEAN_W:0] diff;
   logic [MEAN_W:0]        diff_neg_val;
   logic [MEAN_W-1:0]      diff_mag;
   logic [DIV_W-1:0]       div_dividend, div_quotient;
   logic [SPAN_W-1:0]      div_divisor;
   logic                   div_done;
   logic [MEAN_W-1:0]      num_mean, den_mean;
   logic [ERR_W:0]         err_ext, factor_full;
   logic [FACTOR_W-1:0]    factor;
   logic [ERR_W-1:0]       off_s, q_low;
   logic [OFFSET_W:0]      twice_off;
   logic                   q_big, q_zero, zero_mean;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         offset_ff <= OFFSET_RESET;
         span_ff   <= SPAN_RESET;
         base_ff   <= BASE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET: target_ff <= csr_data[TARGET_W-1:0];
            CSR_OFFSET: offset_ff <= csr_data[OFFSET_W-1:0];
            CSR_SPAN:   span_ff   <= csr_data[SPAN_W-1:0];
            CSR_BASE:   base_ff   <= csr_data[BASE_W-1:0];
            default: ;
         endcase
      end
   end

   // Block accumulation; the last sample of a block latches the means.
   assign rear_sum_in  = rear_sum_ff + SUM_W'(rear_sample);
   assign front_sum_in = front_sum_ff + SUM_W'(front_sample);
   assign block_end    = (count_ff == CNT_W'(BLOCK_LENGTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rear_sum_ff   <= '0;
         front_sum_ff  <= '0;
         rear_mean_ff  <= '0;
         front_mean_ff <= '0;
      end else if (cmd.accept) begin
         if (block_end) begin
            count_ff      <= '0;
            rear_sum_ff   <= '0;
            front_sum_ff  <= '0;
            rear_mean_ff  <= MEAN_W'(rear_sum_in / SUM_W'(BLOCK_LENGTH));
            front_mean_ff <= MEAN_W'(front_sum_in / SUM_W'(BLOCK_LENGTH));
         end else begin
            count_ff     <= count_ff + 1'b1;
            rear_sum_ff  <= rear_sum_in;
            front_sum_ff <= front_sum_in;
         end
      end
   end

   // Signed distance difference; its magnitude goes through the divider.
   assign diff         = $signed({1'b0, target_ff}) - $signed({1'b0, front_mean_ff});
   assign diff_neg_val = -diff;
   assign diff_mag     = diff[MEAN_W] ? diff_neg_val[MEAN_W-1:0] : diff[MEAN_W-1:0];

   // Operand selection for the right motor (side 0) and the left motor (side 1).
   assign num_mean = cmd.side ? rear_mean_ff : front_mean_ff;
   assign den_mean = cmd.side ? front_mean_ff : rear_mean_ff;

   assign div_dividend = cmd.div_power ? DIV_W'(prod_ff[PROD_W-1:Q_FRAC])
                                       : {diff_mag, {Q_FRAC{1'b0}}};
   assign div_divisor  = cmd.div_power ? SPAN_W'(den_mean) : span_ff;

   bascc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign status.div_done = div_done;

   // Error = offset - quotient, clamped to plus or minus offset. A negative
   // difference, a zero quotient or a zero span leaves the error at the offset.
   assign off_s     = {1'b0, offset_ff};
   assign twice_off = {offset_ff, 1'b0};
   assign q_low     = div_quotient[ERR_W-1:0];
   assign q_big     = |div_quotient[DIV_W-1:ERR_W];
   assign q_zero    = (div_quotient == '0);

   always_comb begin
      if ((span_ff == '0) || diff[MEAN_W] || q_zero) begin
         err_in = off_s;
      end else if (q_big || (q_low >= twice_off)) begin
         err_in = ERR_W'(0) - off_s;
      end else begin
         err_in = off_s - q_low;
      end
   end

   // Error factor in Q14: one plus error for the right motor, one minus for the left.
   assign err_ext     = {err_ff[ERR_W-1], err_ff};
   assign factor_full = cmd.side ? (Q_ONE - err_ext) : (Q_ONE + err_ext);
   assign factor      = factor_full[FACTOR_W-1:0];

   // Saturate the power quotient.
   assign clip_in  = |div_quotient[DIV_W-1:POWER_W];
   assign power_in = clip_in ? POWER_MAX : div_quotient[POWER_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.q_capture) begin
         err_ff <= err_in;
      end
      if (cmd.mul1) begin
         bm_ff <= BM_W'(base_ff) * BM_W'(num_mean);
      end
      if (cmd.mul2) begin
         prod_ff <= PROD_W'(bm_ff) * PROD_W'(factor);
      end
      if (cmd.p_capture) begin
         if (cmd.side) begin
            left_ff   <= power_in;
            clip_l_ff <= clip_in;
         end else begin
            right_ff  <= power_in;
            clip_r_ff <= clip_in;
         end
      end
   end

   // Result register; a zero mean forces both powers to zero.
   assign zero_mean = (rear_mean_ff == '0) || (front_mean_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_left_ff  <= zero_mean ? '0 : left_ff;
         rsp_right_ff <= zero_mean ? '0 : right_ff;
         rsp_err_ff   <= err_ff;
         rsp_zero_ff  <= zero_mean;
         rsp_clip_ff  <= !zero_mean && (clip_r_ff || clip_l_ff);
      end
   end

   assign left_power    = rsp_left_ff;
   assign right_power   = rsp_right_ff;
   assign steer_error   = rsp_err_ff;
   assign zero_average  = rsp_zero_ff;
   assign power_clipped = rsp_clip_ff;

endmodule

[rtl/core/bascc_ctrl.sv]
// Controller state machine that sequences one transaction through the datapath.
module bascc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  bascc_pkg::status_type   status,
   output bascc_pkg::cmd_type      cmd
);
   import bascc_pkg::*;

   state_type state_ff, state_in;
   logic      side_ff, side_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      side_in    = side_ff;
      cmd        = '0;
      cmd.side   = side_ff;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_QDIV;
            end
         end
         ST_QDIV: begin
            cmd.div_start = 1'b1;
            state_in      = ST_QWAIT;
         end
         ST_QWAIT: begin
            if (status.div_done) begin
               cmd.q_capture = 1'b1;
               side_in       = 1'b0;
               state_in      = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_PDIV;
         end
         ST_PDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_power = 1'b1;
            state_in      = ST_PWAIT;
         end
         ST_PWAIT: begin
            cmd.div_power = 1'b1;
            if (status.div_done) begin
               cmd.p_capture = 1'b1;
               if (side_ff) begin
                  state_in = ST_DONE;
               end else begin
                  side_in  = 1'b1;
                  state_in = ST_MUL1;
               end
            end
         end
         ST_DONE: begin
            // Wait for the result register to be free.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag: set on load, cleared when the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         side_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule
